// File: src/vpd_pkg.sv
// Shared types, constants, microcode and saturation helpers of the wheel velocity loop.
package vpd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int PC_W      = 6;
  localparam int PROD_W    = 2 * DATA_W;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TS     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INV_TS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_G      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_JN     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_INV_KT = 3'd7;

  localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
    31'd32768, 31'd3276800, 31'd0, 31'd13,
    31'd327680000, 31'd131072, 31'd655, 31'd163840
  };

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL,   // load product register
    OP_MWR,   // write rounded, saturated product
    OP_ADD,
    OP_SUB,
    OP_ADDW,  // load wide sum register
    OP_ADDX   // write saturated wide sum plus operand a
  } op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_TGT, S_MEAS,
    S_KP, S_KI, S_KD, S_TS, S_INV_TS, S_G, S_JN, S_INV_KT,
    S_E, S_VT, S_EST, S_T0, S_T1, S_T2,
    S_EI, S_PE, S_OI, S_LT
  } src_t;

  typedef enum logic [3:0] {
    D_NONE, D_E, D_VT, D_EST, D_T0, D_T1, D_T2,
    D_EI, D_PE, D_OI, D_LT, D_OUT
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t sa;
    src_t sb;
    dst_t dst;
    logic last;
  } uword_t;

  localparam logic [PC_W-1:0] LAST_PC = 6'd32;

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      6'd0:  w = '{OP_SUB,  S_TGT,  S_MEAS,   D_E,    1'b0};
      6'd1:  w = '{OP_MUL,  S_MEAS, S_JN,     D_NONE, 1'b0};
      6'd2:  w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T0,   1'b0};
      6'd3:  w = '{OP_MUL,  S_T0,   S_G,      D_NONE, 1'b0};
      6'd4:  w = '{OP_MWR,  S_ZERO, S_ZERO,   D_VT,   1'b0};
      6'd5:  w = '{OP_SUB,  S_OI,   S_VT,     D_EST,  1'b0};
      6'd6:  w = '{OP_ADD,  S_LT,   S_VT,     D_T0,   1'b0};
      6'd7:  w = '{OP_SUB,  S_T0,   S_OI,     D_T0,   1'b0};
      6'd8:  w = '{OP_MUL,  S_T0,   S_G,      D_NONE, 1'b0};
      6'd9:  w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T0,   1'b0};
      6'd10: w = '{OP_MUL,  S_T0,   S_TS,     D_NONE, 1'b0};
      6'd11: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T0,   1'b0};
      6'd12: w = '{OP_ADD,  S_OI,   S_T0,     D_OI,   1'b0};
      6'd13: w = '{OP_MUL,  S_E,    S_TS,     D_NONE, 1'b0};
      6'd14: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T0,   1'b0};
      6'd15: w = '{OP_ADD,  S_EI,   S_T0,     D_EI,   1'b0};
      6'd16: w = '{OP_SUB,  S_E,    S_PE,     D_T0,   1'b0};
      6'd17: w = '{OP_MUL,  S_T0,   S_INV_TS, D_NONE, 1'b0};
      6'd18: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T0,   1'b0};
      6'd19: w = '{OP_ADD,  S_E,    S_ZERO,   D_PE,   1'b0};
      6'd20: w = '{OP_MUL,  S_KP,   S_E,      D_NONE, 1'b0};
      6'd21: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T1,   1'b0};
      6'd22: w = '{OP_MUL,  S_KI,   S_EI,     D_NONE, 1'b0};
      6'd23: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T2,   1'b0};
      6'd24: w = '{OP_MUL,  S_KD,   S_T0,     D_NONE, 1'b0};
      6'd25: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T0,   1'b0};
      6'd26: w = '{OP_ADDW, S_T1,   S_T2,     D_NONE, 1'b0};
      6'd27: w = '{OP_ADDX, S_T0,   S_ZERO,   D_T0,   1'b0};
      6'd28: w = '{OP_MUL,  S_JN,   S_T0,     D_NONE, 1'b0};
      6'd29: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_T0,   1'b0};
      6'd30: w = '{OP_ADD,  S_T0,   S_EST,    D_LT,   1'b0};
      6'd31: w = '{OP_MUL,  S_LT,   S_INV_KT, D_NONE, 1'b0};
      6'd32: w = '{OP_MWR,  S_ZERO, S_ZERO,   D_OUT,  1'b1};
      default: w = '{OP_NOP, S_ZERO, S_ZERO,  D_NONE, 1'b0};
    endcase
    return w;
  endfunction

  // clamp a 34-bit sum to signed 32 bits
  function automatic logic signed [DATA_W-1:0] sat34(logic signed [DATA_W+1:0] x);
    logic [2:0] top;
    top = x[DATA_W+1:DATA_W-1];
    if (top == 3'b000 || top == 3'b111) return x[DATA_W-1:0];
    return x[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  // round half up, floor by FRAC_BITS, clamp to signed 32 bits
  function automatic logic signed [DATA_W-1:0] rnd_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    logic [PROD_W-DATA_W:0]   top;
    q   = (p + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    top = q[PROD_W-1:DATA_W-1];
    if ((&top) || !(|top)) return q[DATA_W-1:0];
    return q[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage

// File: src/vpd_if.sv
// Valid/ready channels for velocity samples and for loop results.
interface vpd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vpd_pkg::DATA_W-1:0]   target_velocity;
  logic signed [vpd_pkg::DATA_W-1:0]   measured_velocity;

  modport source (output valid, target_velocity, measured_velocity, input ready);
  modport sink   (input valid, target_velocity, measured_velocity, output ready);
endinterface

interface vpd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vpd_pkg::DATA_W-1:0]   current_command;
  logic signed [vpd_pkg::DATA_W-1:0]   disturbance_estimate;

  modport source (output valid, current_command, disturbance_estimate, input ready);
  modport sink   (input valid, current_command, disturbance_estimate, output ready);
endinterface

// File: src/wheel_velocity_pid_with_dob.sv
// A new sample is accepted only while idle; the 33-step microprogram
// runs every multiply and add through the single shared multiplier/adder.
// The final step holds while the previous result has not been taken.
// Synchronous active-low reset restores register defaults and clears the
// integrators, the previous error and the last torque.
module wheel_velocity_pid_with_dob (
  input  logic                                 clk,
  input  logic                                 rst_n,
  vpd_in_if.sink                               in_ch,
  vpd_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vpd_pkg::REG_W-1:0]            cfg_wdata
);

  logic [vpd_pkg::REG_W-1:0]          cfg_r [vpd_pkg::REG_COUNT];
  logic                               busy_r;
  logic [vpd_pkg::PC_W-1:0]           pc_r;
  logic                               out_valid_r;
  logic signed [vpd_pkg::DATA_W-1:0]  tgt_r, meas_r;
  logic signed [vpd_pkg::DATA_W-1:0]  e_r, vt_r, est_r, t0_r, t1_r, t2_r;
  logic signed [vpd_pkg::DATA_W-1:0]  ei_r, pe_r, oi_r, lt_r;
  logic signed [vpd_pkg::DATA_W-1:0]  out_cc_r, out_de_r;

  vpd_pkg::uword_t                    uw;
  logic signed [vpd_pkg::DATA_W-1:0]  opa, opb, res;
  logic                               in_xfer, commit;

  assign uw      = vpd_pkg::ucode(pc_r);
  assign in_xfer = in_ch.valid && in_ch.ready;
  // last step waits for the output register to free up
  assign commit  = busy_r && !(uw.last && out_valid_r && !out_ch.ready);

  assign in_ch.ready                 = !busy_r;
  assign out_ch.valid                = out_valid_r;
  assign out_ch.current_command      = out_cc_r;
  assign out_ch.disturbance_estimate = out_de_r;

  function automatic logic signed [vpd_pkg::DATA_W-1:0] cfg_val(logic [vpd_pkg::REG_W-1:0] v);
    return {1'b0, v};
  endfunction

  function automatic logic signed [vpd_pkg::DATA_W-1:0] pick(vpd_pkg::src_t s);
    logic signed [vpd_pkg::DATA_W-1:0] v;
    unique case (s)
      vpd_pkg::S_TGT:    v = tgt_r;
      vpd_pkg::S_MEAS:   v = meas_r;
      vpd_pkg::S_KP:     v = cfg_val(cfg_r[vpd_pkg::REG_KP]);
      vpd_pkg::S_KI:     v = cfg_val(cfg_r[vpd_pkg::REG_KI]);
      vpd_pkg::S_KD:     v = cfg_val(cfg_r[vpd_pkg::REG_KD]);
      vpd_pkg::S_TS:     v = cfg_val(cfg_r[vpd_pkg::REG_TS]);
      vpd_pkg::S_INV_TS: v = cfg_val(cfg_r[vpd_pkg::REG_INV_TS]);
      vpd_pkg::S_G:      v = cfg_val(cfg_r[vpd_pkg::REG_G]);
      vpd_pkg::S_JN:     v = cfg_val(cfg_r[vpd_pkg::REG_JN]);
      vpd_pkg::S_INV_KT: v = cfg_val(cfg_r[vpd_pkg::REG_INV_KT]);
      vpd_pkg::S_E:      v = e_r;
      vpd_pkg::S_VT:     v = vt_r;
      vpd_pkg::S_EST:    v = est_r;
      vpd_pkg::S_T0:     v = t0_r;
      vpd_pkg::S_T1:     v = t1_r;
      vpd_pkg::S_T2:     v = t2_r;
      vpd_pkg::S_EI:     v = ei_r;
      vpd_pkg::S_PE:     v = pe_r;
      vpd_pkg::S_OI:     v = oi_r;
      vpd_pkg::S_LT:     v = lt_r;
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(uw.sa);
    opb = pick(uw.sb);
  end

  vpd_alu u_alu (
    .clk (clk),
    .op  (uw.op),
    .a   (opa),
    .b   (opb),
    .res (res)
  );

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= vpd_pkg::REG_RESET;
    end else if (cfg_we && cfg_index < vpd_pkg::CFG_IDX_W'(vpd_pkg::REG_COUNT)) begin
      cfg_r[cfg_index[vpd_pkg::REG_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // sequencer control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      ei_r        <= '0;
      pe_r        <= '0;
      oi_r        <= '0;
      lt_r        <= '0;
    end else begin
      if (commit && uw.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
        pc_r   <= '0;
      end else if (commit) begin
        if (uw.last) begin
          busy_r <= 1'b0;
        end else begin
          pc_r <= pc_r + 1'b1;
        end
      end
      if (commit) begin
        case (uw.dst)
          vpd_pkg::D_EI: ei_r <= res;
          vpd_pkg::D_PE: pe_r <= res;
          vpd_pkg::D_OI: oi_r <= res;
          vpd_pkg::D_LT: lt_r <= res;
          default: ;
        endcase
      end
    end
  end

  // datapath temporaries and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tgt_r  <= in_ch.target_velocity;
      meas_r <= in_ch.measured_velocity;
    end
    if (commit) begin
      case (uw.dst)
        vpd_pkg::D_E:   e_r   <= res;
        vpd_pkg::D_VT:  vt_r  <= res;
        vpd_pkg::D_EST: est_r <= res;
        vpd_pkg::D_T0:  t0_r  <= res;
        vpd_pkg::D_T1:  t1_r  <= res;
        vpd_pkg::D_T2:  t2_r  <= res;
        vpd_pkg::D_OUT: begin
          out_cc_r <= res;
          out_de_r <= est_r;
        end
        default: ;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy_r && pc_r == '0)
    else $error("input transfer did not start the program");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= vpd_pkg::LAST_PC)
    else $error("step counter ran past the program");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit && uw.last))
    else $error("result appeared without the final step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_cc_r) && $stable(out_de_r))
    else $error("pending result overwritten");

endmodule

// File: src/vpd_alu.sv
// Shared multiplier with rounding and saturating adder of the velocity loop datapath.
module vpd_alu (
  input  logic                              clk,
  input  vpd_pkg::op_t                      op,
  input  logic signed [vpd_pkg::DATA_W-1:0] a,
  input  logic signed [vpd_pkg::DATA_W-1:0] b,
  output logic signed [vpd_pkg::DATA_W-1:0] res
);

  logic signed [vpd_pkg::PROD_W-1:0] prod_r;
  logic signed [vpd_pkg::DATA_W:0]   wide_r;

  always_ff @(posedge clk) begin
    if (op == vpd_pkg::OP_MUL) begin
      prod_r <= vpd_pkg::PROD_W'(a) * vpd_pkg::PROD_W'(b);
    end
    if (op == vpd_pkg::OP_ADDW) begin
      wide_r <= (vpd_pkg::DATA_W+1)'(a) + (vpd_pkg::DATA_W+1)'(b);
    end
  end

  always_comb begin
    unique case (op)
      vpd_pkg::OP_MWR:  res = vpd_pkg::rnd_sat(prod_r);
      vpd_pkg::OP_ADD:  res = vpd_pkg::sat34((vpd_pkg::DATA_W+2)'(a) +
                                              (vpd_pkg::DATA_W+2)'(b));
      vpd_pkg::OP_SUB:  res = vpd_pkg::sat34((vpd_pkg::DATA_W+2)'(a) -
                                              (vpd_pkg::DATA_W+2)'(b));
      vpd_pkg::OP_ADDX: res = vpd_pkg::sat34((vpd_pkg::DATA_W+2)'(wide_r) +
                                              (vpd_pkg::DATA_W+2)'(a));
      default:          res = '0;
    endcase
  end

endmodule

// File: sim/vpd_loop_checker.sv
// Result checker for the wheel velocity loop: predicts each result and compares it.
module vpd_loop_checker
  import vpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  vpd_in_if                    in_ch,
  vpd_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_W-1:0] current_command;
    logic signed [DATA_W-1:0] disturbance_estimate;
  } loop_result_t;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint GAIN_RESET [REG_COUNT] = '{
    32768, 3276800, 0, 13, 327680000, 131072, 655, 163840
  };

  loop_result_t expected_q [$];
  longint gain [REG_COUNT];
  longint err_sum, prev_err, dob_integ, prev_torque;

  function automatic longint clamp32(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  // exact product, round half up, floor, clamp
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
    return clamp32(p >>> FRAC_BITS);
  endfunction

  // one sample of the loop: observer first, then PID, then torque and current
  function automatic loop_result_t advance_loop(longint target, longint meas);
    longint e, vt, est, d, der, acc, torque;
    loop_result_t r;
    e   = clamp32(target - meas);
    vt  = qmul(qmul(meas, gain[REG_JN]), gain[REG_G]);
    est = clamp32(dob_integ - vt);
    d   = clamp32(clamp32(prev_torque + vt) - dob_integ);
    dob_integ = clamp32(dob_integ + qmul(qmul(d, gain[REG_G]), gain[REG_TS]));
    err_sum = clamp32(err_sum + qmul(e, gain[REG_TS]));
    der = qmul(clamp32(e - prev_err), gain[REG_INV_TS]);
    prev_err = e;
    acc = clamp32(qmul(gain[REG_KP], e) + qmul(gain[REG_KI], err_sum)
                  + qmul(gain[REG_KD], der));
    torque = clamp32(qmul(gain[REG_JN], acc) + est);
    prev_torque = torque;
    r.current_command      = DATA_W'(qmul(torque, gain[REG_INV_KT]));
    r.disturbance_estimate = DATA_W'(est);
    return r;
  endfunction

  function automatic void flag(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    loop_result_t want;
    if (!rst_n) begin
      for (int r = 0; r < REG_COUNT; r++) gain[r] = GAIN_RESET[r];
      err_sum     = 0;
      prev_err    = 0;
      dob_integ   = 0;
      prev_torque = 0;
      expected_q.delete();
    end else begin
      // indexes past the register file are dropped
      if (cfg_we && cfg_index < REG_COUNT)
        gain[cfg_index[REG_IDX_W-1:0]] = longint'(cfg_wdata);
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(advance_loop(in_ch.target_velocity, in_ch.measured_velocity));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual %h %h", $time,
                   out_ch.current_command, out_ch.disturbance_estimate);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.current_command !== want.current_command)
            flag("current_command", want.current_command, out_ch.current_command);
          if (out_ch.disturbance_estimate !== want.disturbance_estimate)
            flag("disturbance_estimate", want.disturbance_estimate,
                 out_ch.disturbance_estimate);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the wheel velocity loop testbench: clock, reset, stimulus and verdict.
module testbench;
  import vpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [DATA_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VEL_MIN = 32'sh8000_0000;
  localparam logic [REG_W-1:0] GAIN_MAX = '1;
  localparam int SMALL_SPAN = 1 << 20;
  localparam int UNIT = 1 << FRAC_BITS;
  localparam int unsigned DEFAULT_GAIN [REG_COUNT] = '{
    32768, 3276800, 0, 13, 327680000, 131072, 655, 163840
  };
  localparam int ITEMS_PER_SET = 67;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_wdata;
  int errors, pending;
  int in_idle_pct, out_idle_pct;
  int hold_cycles;

  vpd_in_if  in_ch ();
  vpd_out_if out_ch ();

  wheel_velocity_pid_with_dob u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  vpd_loop_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("** wheel_velocity_pid_with_dob: FAILED **");
    $finish;
  end

  // result side: random back-pressure, or a long hold-off when one is requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(input logic [REG_W-1:0] data);
    for (int r = 0; r < REG_COUNT; r++) write_reg(CFG_IDX_W'(r), data);
  endtask

  task automatic write_out_of_range();
    write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
              REG_W'($urandom()));
  endtask

  // drop valid and hold until every expected result has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [DATA_W-1:0] tgt,
                             input logic signed [DATA_W-1:0] meas);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.target_velocity   <= tgt;
    in_ch.measured_velocity <= meas;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_velocity();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 50) return DATA_W'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
    if (k < 80) return DATA_W'($urandom());
    if (k < 90) begin
      case ($urandom_range(0, 3))
        0: return VEL_MAX;
        1: return VEL_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return DATA_W'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
  endfunction

  function automatic logic [REG_W-1:0] pick_gain(int r);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 8)  return '0;
    if (k < 16) return GAIN_MAX;
    if (k < 36) return REG_W'($urandom());
    return REG_W'($urandom_range(0, 2 * DEFAULT_GAIN[r] + UNIT));
  endfunction

  task automatic run_random(input int count);
    logic signed [DATA_W-1:0] tgt, meas;
    for (int n = 0; n < count; n++) begin
      tgt = pick_velocity();
      // in 30 percent of samples track the target closely so the integrators stay in range
      if ($urandom_range(0, 99) < 30)
        meas = tgt + DATA_W'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
      else
        meas = pick_velocity();
      send_sample(tgt, meas);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.target_velocity = '0;
    in_ch.measured_velocity = '0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset gains, field extremes
    send_sample('0, '0);
    send_sample(VEL_MAX, VEL_MIN);
    send_sample(VEL_MIN, VEL_MAX);
    send_sample(VEL_MAX, VEL_MAX);
    send_sample(VEL_MIN, VEL_MIN);
    send_sample(32'sd1, -32'sd1);
    send_sample(-32'sd1, 32'sd1);
    send_sample(DATA_W'(UNIT), '0);

    // every gain at its maximum: saturation everywhere
    wait_drained();
    write_all(GAIN_MAX);
    write_out_of_range();
    send_sample(VEL_MAX, VEL_MIN);
    send_sample(VEL_MIN, VEL_MAX);
    send_sample(VEL_MAX, VEL_MAX);
    send_sample(VEL_MIN, VEL_MIN);
    send_sample('0, VEL_MIN);
    send_sample(VEL_MAX, '0);

    // every gain zero: frozen integrators
    wait_drained();
    write_all('0);
    send_sample(VEL_MAX, VEL_MIN);
    send_sample(32'sd1, -32'sd1);
    send_sample(VEL_MIN, VEL_MAX);
    send_sample('0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      for (int set = 0; set < 2; set++) begin
        wait_drained();
        case (phase)
          0: begin in_idle_pct = 6;  out_idle_pct = 84; end
          1: begin in_idle_pct = 84; out_idle_pct = 6;  end
          default: begin in_idle_pct = 0; out_idle_pct = 0; end
        endcase
        for (int r = 0; r < REG_COUNT; r++) write_reg(CFG_IDX_W'(r), pick_gain(r));
        write_out_of_range();
        // stall the result side long enough to back up the input
        if (phase == 2 && set == 0) hold_cycles = 400;
        run_random(ITEMS_PER_SET);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0)
      $display("** wheel_velocity_pid_with_dob: PASSED **");
    else
      $display("** wheel_velocity_pid_with_dob: FAILED **");
    $finish;
  end

endmodule

// File: files.f
src/vpd_pkg.sv
src/vpd_if.sv
src/vpd_alu.sv
src/wheel_velocity_pid_with_dob.sv
sim/vpd_loop_checker.sv
sim/testbench.sv
